>>> design/xbt_pkg.sv
// ----------------------------------------------------------------------------
// xbt_pkg
// shared types, character codes and helpers of the xml byte tokenizer
// ----------------------------------------------------------------------------
package xbt_pkg;

    localparam int TAB_WIDTH = 8;
    localparam int MAX_BEATS = 8;
    localparam int TAB_BEATS = (TAB_WIDTH > MAX_BEATS) ? MAX_BEATS : TAB_WIDTH;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_USCR  = 8'h5F;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_DQUOT = 8'h22;
    localparam logic [7:0] C_SQUOT = 8'h27;

    typedef enum logic [3:0] {
        K_TEXT_BYTE  = 4'd0,
        K_BLANK_DONE = 4'd1,
        K_TEXT_DONE  = 4'd2,
        K_NAME_BYTE  = 4'd3,
        K_NAME_DONE  = 4'd4,
        K_ATTR_BYTE  = 4'd5,
        K_ATTR_DONE  = 4'd6,
        K_VALUE_BYTE = 4'd7,
        K_VALUE_DONE = 4'd8,
        K_TAG_DONE   = 4'd9,
        K_END        = 4'd10,
        K_FAIL       = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        T_HEADER = 2'd0,
        T_OPEN   = 2'd1,
        T_CLOSE  = 2'd2,
        T_SELF   = 2'd3
    } t_tag;

    // one queue entry: up to two distinct beats, or a run of identical beats
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        t_kind            k0;
        t_kind            k1;
        logic [7:0]       d0;
        t_tag             tt;
    } t_cmd;

    function automatic logic name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == C_USCR);
    endfunction

endpackage

>>> design/xbt_if.sv
// ----------------------------------------------------------------------------
// xbt_if
// valid/ready channels for input bytes and result beats
// ----------------------------------------------------------------------------
interface xbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       at_end;

    modport source (output valid, output in_byte, output at_end, input ready);
    modport sink   (input valid, input in_byte, input at_end, output ready);
endinterface

interface xbt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] data_byte;
    logic [1:0] tag_type;
    logic       last_of_run;

    modport source (output valid, output kind, output data_byte, output tag_type,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input data_byte, input tag_type,
                    input last_of_run, output ready);
endinterface

>>> design/xbt_front.sv
// ----------------------------------------------------------------------------
// xbt_front
// lexer state machine: classifies each byte into a queue command
// ----------------------------------------------------------------------------
module xbt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    xbt_in_if.sink            i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output xbt_pkg::t_cmd     o_cmd
);

    typedef enum logic [15:0] {
        M_IDLE      = 16'h0001,
        M_TEXT      = 16'h0002,
        M_TAG_BEGIN = 16'h0004,
        M_TAG_NAME  = 16'h0008,
        M_TAG       = 16'h0010,
        M_ATTR      = 16'h0020,
        M_VALUE     = 16'h0040,
        M_STRING    = 16'h0080,
        M_TAG_END   = 16'h0100,
        M_TAG_CLOSE = 16'h0200,
        M_CMT_B1    = 16'h0400,
        M_CMT_B2    = 16'h0800,
        M_CMT       = 16'h1000,
        M_CMT_E1    = 16'h2000,
        M_CMT_E2    = 16'h4000,
        M_FAILED    = 16'h8000
    } t_mode;

    t_mode         r_mode, n_mode;
    xbt_pkg::t_tag r_tag_kind, n_tag_kind;
    logic          r_nonblank, n_nonblank;
    logic          r_quote_dbl, n_quote_dbl;
    xbt_pkg::t_cmd cmd;
    logic          accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        logic                 again;
        logic                 pv;
        logic                 tab;
        xbt_pkg::t_kind       pk;
        logic [7:0]           pd;
        logic [7:0]           c;
        logic                 eof;
        c           = i_in.in_byte;
        eof         = i_in.at_end;
        n_mode      = r_mode;
        n_tag_kind  = r_tag_kind;
        n_nonblank  = r_nonblank;
        n_quote_dbl = r_quote_dbl;
        cmd.cnt     = '0;
        cmd.k0      = xbt_pkg::K_TEXT_BYTE;
        cmd.k1      = xbt_pkg::K_TEXT_BYTE;
        cmd.d0      = 8'h00;
        cmd.tt      = xbt_pkg::T_HEADER;
        again       = 1'b1;
        pv          = 1'b0;
        tab         = 1'b0;
        pk          = xbt_pkg::K_FAIL;
        pd          = 8'h00;
        // at most three passes: tag name -> tag end -> tag close
        for (int p = 0; p < 3; p++) begin
            if (again) begin
                again = 1'b0;
                pv    = 1'b0;
                tab   = 1'b0;
                pk    = xbt_pkg::K_FAIL;
                pd    = 8'h00;
                unique case (n_mode)
                    M_IDLE: begin
                        if (eof) begin
                            pv = 1'b1; pk = xbt_pkg::K_END;
                        end else if (c == xbt_pkg::C_CR || c == xbt_pkg::C_LF) begin
                            pv = 1'b0;
                        end else if (c == xbt_pkg::C_LT) begin
                            n_mode = M_TAG_BEGIN;
                        end else begin
                            n_mode     = M_TEXT;
                            n_nonblank = 1'b0;
                            again      = 1'b1;
                        end
                    end
                    M_TEXT: begin
                        if (eof) begin
                            pv = 1'b1;
                            pk = n_nonblank ? xbt_pkg::K_TEXT_DONE : xbt_pkg::K_BLANK_DONE;
                            n_mode = M_IDLE;
                            // end beat follows as the second beat of the same entry
                            cmd.k0  = pk;
                            cmd.k1  = xbt_pkg::K_END;
                            cmd.cnt = xbt_pkg::CNT_W'(2);
                            pv      = 1'b0;
                        end else if (c == xbt_pkg::C_SPACE) begin
                            pv = 1'b1; pk = xbt_pkg::K_TEXT_BYTE; pd = c;
                        end else if (c == xbt_pkg::C_TAB) begin
                            tab = 1'b1; pk = xbt_pkg::K_TEXT_BYTE;
                        end else if (c == xbt_pkg::C_CR || c == xbt_pkg::C_LF) begin
                            pv = 1'b0;
                        end else if (c == xbt_pkg::C_LT) begin
                            pv = 1'b1;
                            pk = n_nonblank ? xbt_pkg::K_TEXT_DONE : xbt_pkg::K_BLANK_DONE;
                            n_mode = M_TAG_BEGIN;
                        end else begin
                            n_nonblank = 1'b1;
                            pv = 1'b1; pk = xbt_pkg::K_TEXT_BYTE; pd = c;
                        end
                    end
                    M_TAG_BEGIN: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_BANG) begin
                            n_mode = M_CMT_B1;
                        end else if (c == xbt_pkg::C_QMARK) begin
                            n_mode = M_TAG_NAME; n_tag_kind = xbt_pkg::T_HEADER;
                        end else if (c == xbt_pkg::C_SLASH) begin
                            n_mode = M_TAG_NAME; n_tag_kind = xbt_pkg::T_CLOSE;
                        end else if (xbt_pkg::name_char(c)) begin
                            n_mode = M_TAG_NAME; n_tag_kind = xbt_pkg::T_OPEN;
                            again  = 1'b1;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_TAG_NAME: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (xbt_pkg::name_char(c)) begin
                            pv = 1'b1; pk = xbt_pkg::K_NAME_BYTE; pd = c;
                        end else if (c == xbt_pkg::C_SPACE || c == xbt_pkg::C_TAB) begin
                            pv = 1'b1; pk = xbt_pkg::K_NAME_DONE; n_mode = M_TAG;
                        end else if (c == xbt_pkg::C_QMARK || c == xbt_pkg::C_SLASH
                                     || c == xbt_pkg::C_GT) begin
                            pv = 1'b1; pk = xbt_pkg::K_NAME_DONE; n_mode = M_TAG_END;
                            again = 1'b1;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_TAG: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_SPACE || c == xbt_pkg::C_TAB) begin
                            pv = 1'b0;
                        end else if (xbt_pkg::name_char(c)) begin
                            n_mode = M_ATTR; again = 1'b1;
                        end else if (c == xbt_pkg::C_QMARK || c == xbt_pkg::C_SLASH
                                     || c == xbt_pkg::C_GT) begin
                            n_mode = M_TAG_END; again = 1'b1;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_ATTR: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (xbt_pkg::name_char(c)) begin
                            pv = 1'b1; pk = xbt_pkg::K_ATTR_BYTE; pd = c;
                        end else if (c == xbt_pkg::C_EQ) begin
                            pv = 1'b1; pk = xbt_pkg::K_ATTR_DONE; n_mode = M_VALUE;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_VALUE: begin
                        if (!eof && (c == xbt_pkg::C_SQUOT || c == xbt_pkg::C_DQUOT)) begin
                            n_quote_dbl = (c == xbt_pkg::C_DQUOT);
                            n_mode      = M_STRING;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_STRING: begin
                        if (eof || c == xbt_pkg::C_CR || c == xbt_pkg::C_LF) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == (n_quote_dbl ? xbt_pkg::C_DQUOT
                                                       : xbt_pkg::C_SQUOT)) begin
                            pv = 1'b1; pk = xbt_pkg::K_VALUE_DONE; n_mode = M_TAG;
                        end else if (c == xbt_pkg::C_TAB) begin
                            tab = 1'b1; pk = xbt_pkg::K_VALUE_BYTE;
                        end else begin
                            pv = 1'b1; pk = xbt_pkg::K_VALUE_BYTE; pd = c;
                        end
                    end
                    M_TAG_END: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_QMARK
                                     && n_tag_kind == xbt_pkg::T_HEADER) begin
                            n_mode = M_TAG_CLOSE;
                        end else if (c == xbt_pkg::C_SLASH
                                     && n_tag_kind == xbt_pkg::T_OPEN) begin
                            n_tag_kind = xbt_pkg::T_SELF;
                            n_mode     = M_TAG_CLOSE;
                        end else if (c == xbt_pkg::C_GT
                                     && (n_tag_kind == xbt_pkg::T_OPEN
                                         || n_tag_kind == xbt_pkg::T_CLOSE)) begin
                            n_mode = M_TAG_CLOSE; again = 1'b1;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_TAG_CLOSE: begin
                        if (!eof && c == xbt_pkg::C_GT) begin
                            pv = 1'b1; pk = xbt_pkg::K_TAG_DONE; n_mode = M_IDLE;
                            cmd.tt = n_tag_kind;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_CMT_B1: begin
                        if (!eof && c == xbt_pkg::C_DASH) begin
                            n_mode = M_CMT_B2;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_CMT_B2: begin
                        if (!eof && c == xbt_pkg::C_DASH) begin
                            n_mode = M_CMT;
                        end else begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end
                    end
                    M_CMT: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_DASH) begin
                            n_mode = M_CMT_E1;
                        end
                    end
                    M_CMT_E1: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_DASH) begin
                            n_mode = M_CMT_E2;
                        end else begin
                            n_mode = M_CMT;
                        end
                    end
                    M_CMT_E2: begin
                        if (eof) begin
                            pv = 1'b1; n_mode = M_FAILED;
                        end else if (c == xbt_pkg::C_GT) begin
                            n_mode = M_IDLE;
                        end else if (c != xbt_pkg::C_DASH) begin
                            n_mode = M_CMT;
                        end
                    end
                    M_FAILED: begin
                        pv = 1'b0;
                    end
                    default: begin
                        pv = 1'b1; n_mode = M_FAILED;
                    end
                endcase
                // append this pass's beat to the command, or make it a run of spaces for a tab
                if (tab) begin
                    cmd.cnt = xbt_pkg::CNT_W'(xbt_pkg::TAB_BEATS);
                    cmd.k0  = pk;
                    cmd.k1  = pk;
                    cmd.d0  = xbt_pkg::C_SPACE;
                end else if (pv) begin
                    if (cmd.cnt == '0) begin
                        cmd.k0 = pk;
                        cmd.k1 = pk;
                        cmd.d0 = pd;
                    end else begin
                        cmd.k1 = pk;
                    end
                    cmd.cnt = cmd.cnt + 1'b1;
                end
            end
        end
    end

    assign o_push = accept && (cmd.cnt != '0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_tag_kind  <= xbt_pkg::T_HEADER;
            r_nonblank  <= 1'b0;
            r_quote_dbl <= 1'b0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_tag_kind  <= n_tag_kind;
            r_nonblank  <= n_nonblank;
            r_quote_dbl <= n_quote_dbl;
        end
    end

endmodule

>>> design/xbt_queue.sv
// ----------------------------------------------------------------------------
// xbt_queue
// short command queue between the lexer and the beat generator
// ----------------------------------------------------------------------------
module xbt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xbt_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output xbt_pkg::t_cmd     o_cmd
);

    xbt_pkg::t_cmd              r_mem [xbt_pkg::Q_DEPTH];
    logic [xbt_pkg::Q_AW-1:0]   r_wr, n_wr;
    logic [xbt_pkg::Q_AW-1:0]   r_rd, n_rd;
    logic [xbt_pkg::Q_AW:0]     r_count, n_count;

    assign o_full  = (r_count == (xbt_pkg::Q_AW+1)'(xbt_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (xbt_pkg::Q_AW+1)'(i_push) - (xbt_pkg::Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> design/xbt_back.sv
// ----------------------------------------------------------------------------
// xbt_back
// expands queue commands into result beats through an output register
// ----------------------------------------------------------------------------
module xbt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  xbt_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    xbt_out_if.source         o_out
);

    logic [xbt_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                      r_valid, n_valid;
    xbt_pkg::t_kind            r_kind, n_kind;
    logic [7:0]                r_data, n_data;
    xbt_pkg::t_tag             r_tag, n_tag;
    logic                      r_last, n_last;
    logic                      load;
    logic                      last;

    assign load = !r_valid || o_out.ready;
    assign last = (r_idx + 1'b1) == i_cmd.cnt;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_data  = r_data;
        n_tag   = r_tag;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_valid;
            if (i_valid) begin
                n_kind = (r_idx == '0) ? i_cmd.k0 : i_cmd.k1;
                case (n_kind) inside
                    xbt_pkg::K_TEXT_BYTE, xbt_pkg::K_NAME_BYTE,
                    xbt_pkg::K_ATTR_BYTE, xbt_pkg::K_VALUE_BYTE: n_data = i_cmd.d0;
                    default: n_data = 8'h00;
                endcase
                n_tag  = (n_kind == xbt_pkg::K_TAG_DONE) ? i_cmd.tt : xbt_pkg::T_HEADER;
                n_last = last;
                o_pop  = last;
                n_idx  = last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_tag  <= n_tag;
        r_last <= n_last;
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.data_byte   = r_data;
    assign o_out.tag_type    = r_tag;
    assign o_out.last_of_run = r_last;

endmodule

>>> design/xml_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// xml_byte_tokenizer_core
// streaming tokenizer for a simple xml subset, one byte per beat
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one character (in_byte) or an end-of-input mark (at_end)
//   per beat; o_out carries result beats (kind, data_byte, tag_type) with
//   last_of_run set on the final beat caused by an input beat.
//   an input beat is classified by the lexer in the cycle it is accepted and
//   its beats are queued; they reach o_out through the command queue and then
//   the output register. the output register emits one result beat per cycle
//   while the receiver is ready, so an input beat giving one result sustains
//   one input beat per cycle; a tab gives TAB_WIDTH beats (at most eight),
//   emitted in turn. input beats giving no result (comments, line breaks,
//   opening quotes) put nothing on the output. when the receiver stalls the
//   output register holds, the four-entry command queue fills, and i_in.ready
//   drops once it is full. synchronous reset returns the lexer to idle and
//   empties the queue and the output register; after a fail beat all input is
//   taken and dropped until the next reset.
// ----------------------------------------------------------------------------
module xml_byte_tokenizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xbt_in_if.sink    i_in,
    xbt_out_if.source o_out
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    xbt_pkg::t_cmd q_wr_cmd;
    xbt_pkg::t_cmd q_rd_cmd;

    xbt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_wr_cmd)
    );

    xbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_rd_cmd)
    );

    xbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_rd_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == xbt_pkg::K_FAIL) |-> o_out.last_of_run)
        else $error("fail beat not last of run");

    a_tag_type_only_on_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != xbt_pkg::K_TAG_DONE) |-> (o_out.tag_type == 2'd0))
        else $error("tag type on a non-tag beat");

    a_data_only_on_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data_byte != 8'h00) |->
            (o_out.kind == xbt_pkg::K_TEXT_BYTE || o_out.kind == xbt_pkg::K_NAME_BYTE
             || o_out.kind == xbt_pkg::K_ATTR_BYTE || o_out.kind == xbt_pkg::K_VALUE_BYTE))
        else $error("data on a non-byte beat");

endmodule

>>> tb/tb_xml_byte_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_byte_tokenizer_core
// self-checking bench for the xml byte tokenizer core
// ----------------------------------------------------------------------------
// a short directed stream walks header, attribute, value, tab, comment, blank
// text and end-of-input handling, then random well-formed documents (text,
// tags with attributes, comments, line breaks, end marks) follow and the run
// closes on one malformed sequence. every accepted beat is fed to a local
// tokenizer model and each result beat is compared field by field. both
// sides idle in short random bursts, and once the receiver holds off long
// enough for the core to stall its input.
// ----------------------------------------------------------------------------
module tb_xml_byte_tokenizer_core;
    import xbt_pkg::*;

    localparam int   RUN_LIMIT  = 200000;
    localparam int   CALM_ITEMS = 60;
    localparam int   HOLD_AT    = 150;
    localparam int   HOLD_LEN   = 64;
    localparam t_tag TT_NONE    = T_HEADER;

    typedef enum logic [4:0] {
        LX_IDLE      = 5'd0,
        LX_TEXT      = 5'd1,
        LX_TAG_BEGIN = 5'd2,
        LX_TAG_NAME  = 5'd3,
        LX_TAG       = 5'd4,
        LX_ATTR      = 5'd5,
        LX_VALUE     = 5'd6,
        LX_STRING    = 5'd7,
        LX_TAG_END   = 5'd8,
        LX_TAG_CLOSE = 5'd9,
        LX_CMT_B1    = 5'd10,
        LX_CMT_B2    = 5'd11,
        LX_CMT       = 5'd12,
        LX_CMT_E1    = 5'd13,
        LX_CMT_E2    = 5'd14,
        LX_FAILED    = 5'd15
    } lex_mode_t;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        t_tag       tt;
        logic       last;
    } beat_t;

    typedef struct {
        logic [7:0] b;
        bit         eof;
    } char_t;

    typedef struct {
        logic [7:0] b;
        bit         eof;
        bit         typed;
        t_kind      k;
        logic [7:0] d;
        t_tag       t;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xbt_in_if  in_if ();
    xbt_out_if out_if ();

    xml_byte_tokenizer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tokenizer model state
    lex_mode_t lx_mode   = LX_IDLE;
    t_tag      cur_tag   = T_HEADER;
    bit        text_seen = 1'b0;
    bit        dq_quote  = 1'b0;

    beat_t step_beats [$];
    beat_t beats_due  [$];
    char_t doc_chars  [$];

    int  n_errors      = 0;
    int  items_sent    = 0;
    int  beats_checked = 0;
    int  tags_checked  = 0;
    int  fails_checked = 0;
    int  cycle_cnt     = 0;
    bit  calm          = 1'b0;
    bit  held_off      = 1'b0;

    dir_row_t dir_rows [0:24] = '{
        '{8'h00,   1'b1, 1'b1, K_END,        8'h00, TT_NONE},
        '{C_LF,    1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_LT,    1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_QMARK, 1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{"x",     1'b0, 1'b1, K_NAME_BYTE,  "x",   TT_NONE},
        '{C_SPACE, 1'b0, 1'b1, K_NAME_DONE,  8'h00, TT_NONE},
        '{"a",     1'b0, 1'b1, K_ATTR_BYTE,  "a",   TT_NONE},
        '{C_EQ,    1'b0, 1'b1, K_ATTR_DONE,  8'h00, TT_NONE},
        '{C_DQUOT, 1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_TAB,   1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_SQUOT, 1'b0, 1'b1, K_VALUE_BYTE, C_SQUOT, TT_NONE},
        '{8'hFF,   1'b0, 1'b1, K_VALUE_BYTE, 8'hFF, TT_NONE},
        '{C_DQUOT, 1'b0, 1'b1, K_VALUE_DONE, 8'h00, TT_NONE},
        '{C_QMARK, 1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_GT,    1'b0, 1'b1, K_TAG_DONE,   8'h00, T_HEADER},
        '{C_TAB,   1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_LT,    1'b0, 1'b1, K_BLANK_DONE, 8'h00, TT_NONE},
        '{C_BANG,  1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_DASH,  1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_DASH,  1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_DASH,  1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_DASH,  1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{C_GT,    1'b0, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{8'h00,   1'b0, 1'b1, K_TEXT_BYTE,  8'h00, TT_NONE},
        '{8'hA5,   1'b1, 1'b0, K_TEXT_BYTE,  8'h00, TT_NONE}
    };

    // ------------------------------------------------------------------
    // tokenizer model
    // ------------------------------------------------------------------
    function automatic bit is_name_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == C_USCR;
    endfunction

    function automatic bit is_tag_end_ch(logic [7:0] c);
        return c == C_QMARK || c == C_SLASH || c == C_GT;
    endfunction

    function automatic void put_beat(t_kind k, logic [7:0] d, t_tag t);
        beat_t b;
        if (step_beats.size() >= MAX_BEATS) return;
        b.kind = k;
        b.data = d;
        b.tt   = t;
        b.last = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void put_spaces(t_kind k);
        repeat (TAB_WIDTH) put_beat(k, C_SPACE, TT_NONE);
    endfunction

    function automatic void flag_fail();
        put_beat(K_FAIL, 8'h00, TT_NONE);
        lx_mode = LX_FAILED;
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, bit eof);
        bit again;
        step_beats.delete();
        if (lx_mode == LX_FAILED) return;
        do begin
            again = 1'b0;
            case (lx_mode)
                LX_IDLE: begin
                    if (eof) begin
                        put_beat(K_END, 8'h00, TT_NONE);
                    end else if (c == C_LT) begin
                        lx_mode = LX_TAG_BEGIN;
                    end else if (c != C_CR && c != C_LF) begin
                        lx_mode   = LX_TEXT;
                        text_seen = 1'b0;
                        again     = 1'b1;
                    end
                end
                LX_TEXT: begin
                    if (eof) begin
                        put_beat(text_seen ? K_TEXT_DONE : K_BLANK_DONE, 8'h00, TT_NONE);
                        put_beat(K_END, 8'h00, TT_NONE);
                        lx_mode = LX_IDLE;
                    end else if (c == C_SPACE) begin
                        put_beat(K_TEXT_BYTE, C_SPACE, TT_NONE);
                    end else if (c == C_TAB) begin
                        put_spaces(K_TEXT_BYTE);
                    end else if (c == C_LT) begin
                        put_beat(text_seen ? K_TEXT_DONE : K_BLANK_DONE, 8'h00, TT_NONE);
                        lx_mode = LX_TAG_BEGIN;
                    end else if (c != C_CR && c != C_LF) begin
                        text_seen = 1'b1;
                        put_beat(K_TEXT_BYTE, c, TT_NONE);
                    end
                end
                LX_TAG_BEGIN: begin
                    if (eof) begin
                        flag_fail();
                    end else if (c == C_BANG) begin
                        lx_mode = LX_CMT_B1;
                    end else if (c == C_QMARK) begin
                        lx_mode = LX_TAG_NAME;
                        cur_tag = T_HEADER;
                    end else if (c == C_SLASH) begin
                        lx_mode = LX_TAG_NAME;
                        cur_tag = T_CLOSE;
                    end else if (is_name_ch(c)) begin
                        lx_mode = LX_TAG_NAME;
                        cur_tag = T_OPEN;
                        again   = 1'b1;
                    end else begin
                        flag_fail();
                    end
                end
                LX_TAG_NAME: begin
                    if (eof) begin
                        flag_fail();
                    end else if (is_name_ch(c)) begin
                        put_beat(K_NAME_BYTE, c, TT_NONE);
                    end else if (c == C_SPACE || c == C_TAB) begin
                        put_beat(K_NAME_DONE, 8'h00, TT_NONE);
                        lx_mode = LX_TAG;
                    end else if (is_tag_end_ch(c)) begin
                        put_beat(K_NAME_DONE, 8'h00, TT_NONE);
                        lx_mode = LX_TAG_END;
                        again   = 1'b1;
                    end else begin
                        flag_fail();
                    end
                end
                LX_TAG: begin
                    if (eof) begin
                        flag_fail();
                    end else if (is_name_ch(c)) begin
                        lx_mode = LX_ATTR;
                        again   = 1'b1;
                    end else if (is_tag_end_ch(c)) begin
                        lx_mode = LX_TAG_END;
                        again   = 1'b1;
                    end else if (c != C_SPACE && c != C_TAB) begin
                        flag_fail();
                    end
                end
                LX_ATTR: begin
                    if (eof) begin
                        flag_fail();
                    end else if (is_name_ch(c)) begin
                        put_beat(K_ATTR_BYTE, c, TT_NONE);
                    end else if (c == C_EQ) begin
                        put_beat(K_ATTR_DONE, 8'h00, TT_NONE);
                        lx_mode = LX_VALUE;
                    end else begin
                        flag_fail();
                    end
                end
                LX_VALUE: begin
                    if (!eof && (c == C_SQUOT || c == C_DQUOT)) begin
                        dq_quote = (c == C_DQUOT);
                        lx_mode  = LX_STRING;
                    end else begin
                        flag_fail();
                    end
                end
                LX_STRING: begin
                    if (eof || c == C_CR || c == C_LF) begin
                        flag_fail();
                    end else if (c == (dq_quote ? C_DQUOT : C_SQUOT)) begin
                        put_beat(K_VALUE_DONE, 8'h00, TT_NONE);
                        lx_mode = LX_TAG;
                    end else if (c == C_TAB) begin
                        put_spaces(K_VALUE_BYTE);
                    end else begin
                        put_beat(K_VALUE_BYTE, c, TT_NONE);
                    end
                end
                LX_TAG_END: begin
                    if (eof) begin
                        flag_fail();
                    end else if (c == C_QMARK && cur_tag == T_HEADER) begin
                        lx_mode = LX_TAG_CLOSE;
                    end else if (c == C_SLASH && cur_tag == T_OPEN) begin
                        cur_tag = T_SELF;
                        lx_mode = LX_TAG_CLOSE;
                    end else if (c == C_GT && (cur_tag == T_OPEN || cur_tag == T_CLOSE)) begin
                        lx_mode = LX_TAG_CLOSE;
                        again   = 1'b1;
                    end else begin
                        flag_fail();
                    end
                end
                LX_TAG_CLOSE: begin
                    if (!eof && c == C_GT) begin
                        put_beat(K_TAG_DONE, 8'h00, cur_tag);
                        lx_mode = LX_IDLE;
                    end else begin
                        flag_fail();
                    end
                end
                LX_CMT_B1: begin
                    if (!eof && c == C_DASH) lx_mode = LX_CMT_B2;
                    else flag_fail();
                end
                LX_CMT_B2: begin
                    if (!eof && c == C_DASH) lx_mode = LX_CMT;
                    else flag_fail();
                end
                LX_CMT: begin
                    if (eof) flag_fail();
                    else if (c == C_DASH) lx_mode = LX_CMT_E1;
                end
                LX_CMT_E1: begin
                    if (eof) flag_fail();
                    else if (c == C_DASH) lx_mode = LX_CMT_E2;
                    else lx_mode = LX_CMT;
                end
                LX_CMT_E2: begin
                    if (eof) flag_fail();
                    else if (c == C_GT) lx_mode = LX_IDLE;
                    else if (c != C_DASH) lx_mode = LX_CMT;
                end
                default: begin
                    flag_fail();
                end
            endcase
        end while (again);
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random document builder
    // ------------------------------------------------------------------
    function automatic void push_char(logic [7:0] b, bit eof);
        char_t ch;
        ch.b   = b;
        ch.eof = eof;
        doc_chars.push_back(ch);
    endfunction

    function automatic logic [7:0] pick_name_ch();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return "a" + 8'(r);
        if (r < 52) return "A" + 8'(r - 26);
        return C_USCR;
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? C_SPACE : C_TAB;
    endfunction

    function automatic void add_text();
        bit         blank;
        logic [7:0] c;
        blank = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0: c = C_SPACE;
                1: c = C_TAB;
                2: c = blank ? C_SPACE : ($urandom_range(0, 1) ? C_CR : C_LF);
                default: begin
                    if (blank) begin
                        c = C_TAB;
                    end else begin
                        do c = 8'($urandom_range(0, 255)); while (c == C_LT);
                    end
                end
            endcase
            push_char(c, 1'b0);
        end
    endfunction

    function automatic void add_tag();
        t_tag       tt;
        logic [7:0] q;
        logic [7:0] c;
        tt = t_tag'($urandom_range(0, 3));
        push_char(C_LT, 1'b0);
        if (tt == T_HEADER) push_char(C_QMARK, 1'b0);
        if (tt == T_CLOSE) push_char(C_SLASH, 1'b0);
        repeat ($urandom_range(1, 5)) push_char(pick_name_ch(), 1'b0);
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 2)) push_char(pick_blank(), 1'b0);
            repeat ($urandom_range(1, 4)) push_char(pick_name_ch(), 1'b0);
            push_char(C_EQ, 1'b0);
            q = $urandom_range(0, 1) ? C_DQUOT : C_SQUOT;
            push_char(q, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 5) == 0) begin
                    c = C_TAB;
                end else begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == q || c == C_CR || c == C_LF);
                end
                push_char(c, 1'b0);
            end
            push_char(q, 1'b0);
        end
        if ($urandom_range(0, 2) == 0) push_char(pick_blank(), 1'b0);
        case (tt)
            T_HEADER: push_char(C_QMARK, 1'b0);
            T_SELF:   push_char(C_SLASH, 1'b0);
            default: begin
            end
        endcase
        push_char(C_GT, 1'b0);
    endfunction

    function automatic void add_comment();
        logic [7:0] c;
        push_char(C_LT, 1'b0);
        push_char(C_BANG, 1'b0);
        push_char(C_DASH, 1'b0);
        push_char(C_DASH, 1'b0);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 2) == 0) begin
                c = C_DASH;
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == C_LT || c == C_GT);
            end
            push_char(c, 1'b0);
        end
        push_char(C_DASH, 1'b0);
        push_char(C_DASH, 1'b0);
        push_char(C_GT, 1'b0);
    endfunction

    // one malformed sequence closes the document, then a few dropped beats
    function automatic void add_broken();
        push_char(C_LT, 1'b0);
        case ($urandom_range(0, 3))
            0: begin
                push_char("a", 1'b0);
                push_char(C_SPACE, 1'b0);
                push_char("b", 1'b0);
                push_char(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                push_char("a", 1'b0);
                push_char(C_SPACE, 1'b0);
                push_char("b", 1'b0);
                push_char(C_EQ, 1'b0);
                push_char(C_DQUOT, 1'b0);
                push_char($urandom_range(0, 1) ? C_CR : C_LF, 1'b0);
            end
            2: begin
                push_char("1", 1'b0);
            end
            default: begin
                push_char(C_BANG, 1'b0);
                push_char(C_DASH, 1'b0);
                push_char("x", 1'b0);
            end
        endcase
        repeat (3) push_char(8'($urandom_range(0, 255)), 1'b0);
        push_char(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    function automatic void build_document();
        while (doc_chars.size() < 335) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    add_text();
                3, 4, 5, 6: add_tag();
                7:          add_comment();
                8:          push_char(8'($urandom_range(0, 255)), 1'b1);
                default:    push_char($urandom_range(0, 1) ? C_CR : C_LF, 1'b0);
            endcase
        end
        add_broken();
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic offer_char(logic [7:0] b, bit eof);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.at_end  <= eof;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
        tokenize_byte(b, eof);
        foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    function automatic void check_beat();
        beat_t e;
        if (beats_due.size() == 0) begin
            $display("%0t unexpected beat: kind %0d data %h tag %0d last %0d", $time,
                     out_if.kind, out_if.data_byte, out_if.tag_type, out_if.last_of_run);
            n_errors++;
            return;
        end
        e = beats_due.pop_front();
        beats_checked++;
        if (e.kind == K_TAG_DONE) tags_checked++;
        if (e.kind == K_FAIL) fails_checked++;
        if (out_if.kind !== e.kind) begin
            $display("%0t kind mismatch: expected %0d, actual %0d", $time, e.kind, out_if.kind);
            n_errors++;
        end
        if (out_if.data_byte !== e.data) begin
            $display("%0t data mismatch: expected %h, actual %h", $time, e.data,
                     out_if.data_byte);
            n_errors++;
        end
        if (out_if.tag_type !== e.tt) begin
            $display("%0t tag type mismatch: expected %0d, actual %0d", $time, e.tt,
                     out_if.tag_type);
            n_errors++;
        end
        if (out_if.last_of_run !== e.last) begin
            $display("%0t last flag mismatch: expected %0d, actual %0d", $time, e.last,
                     out_if.last_of_run);
            n_errors++;
        end
    endfunction

    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!held_off && items_sent >= HOLD_AT) begin
                // long hold so the command queue fills and input ready drops
                held_off   = 1'b1;
                stall_left = HOLD_LEN - 1;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_beat();
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= RUN_LIMIT);
        $display("%0t run timed out, %0d beats still expected", $time, beats_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int total;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'h00;
        in_if.at_end  <= 1'b0;
        build_document();
        total = $size(dir_rows) + doc_chars.size();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_char(dir_rows[i].b, dir_rows[i].eof);
            if (dir_rows[i].typed && (step_beats.size() != 1 ||
                step_beats[0].kind != dir_rows[i].k ||
                step_beats[0].data != dir_rows[i].d ||
                step_beats[0].tt != dir_rows[i].t)) begin
                $display("%0t directed beat %0d: expected kind %0d data %h tag %0d, %0d beats",
                         $time, i, dir_rows[i].k, dir_rows[i].d, dir_rows[i].t,
                         step_beats.size());
                if (step_beats.size() > 0) begin
                    $display("%0t directed beat %0d: actual kind %0d data %h tag %0d",
                             $time, i, step_beats[0].kind, step_beats[0].data,
                             step_beats[0].tt);
                end
                n_errors++;
            end
        end

        foreach (doc_chars[i]) begin
            calm = ($size(dir_rows) + i >= total - CALM_ITEMS);
            offer_char(doc_chars[i].b, doc_chars[i].eof);
        end
        in_if.valid <= 1'b0;

        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d input beats (%0d directed), %0d result beats checked",
                 items_sent, $size(dir_rows), beats_checked);
        $display("tag-done beats %0d, fail beats %0d, long receiver hold %0s",
                 tags_checked, fails_checked, held_off ? "done" : "missed");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/xbt_pkg.sv
design/xbt_if.sv
design/xbt_front.sv
design/xbt_queue.sv
design/xbt_back.sv
design/xml_byte_tokenizer_core.sv
tb/tb_xml_byte_tokenizer_core.sv
